FILE: hdl/sfa_pkg.sv
// sfa_pkg: widths, register indexes, sequencer states and saturation helpers
// shared by the separation force accumulator and its arithmetic units
// depends on nothing
package sfa_pkg;

  // field and register widths
  localparam int POS_W     = 24;
  localparam int FRAC_BITS = 12;
  localparam int REG_W     = 23;
  localparam int DELTA_W   = POS_W + 1;
  localparam int ACC_W     = 32;
  localparam int CFG_IDX_W = 2;

  // shared multiplier
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  // square root unit
  localparam int ROOT_W = 32;
  localparam int RAD_W  = 2 * ROOT_W;

  // divider: factor numerator is gain*(s-d) shifted by the fraction bits
  localparam int DIV_NUM_W = 2 * REG_W + FRAC_BITS;
  localparam int DIV_DEN_W = 2 * REG_W;

  // per-axis step: |delta| times the factor, factor split in two halves
  localparam int FAC_HALF = (DIV_NUM_W + 1) / 2;
  localparam int STEP_W   = REG_W + DIV_NUM_W;
  localparam int CAP_BITS = 40;
  localparam int SUM_W    = CAP_BITS + 3;

  // register reset values: 2.0, 1.0 and 4.0
  localparam logic [REG_W-1:0] SEP_DIST_RST  = REG_W'(2) << FRAC_BITS;
  localparam logic [REG_W-1:0] SEP_GAIN_RST  = REG_W'(1) << FRAC_BITS;
  localparam logic [REG_W-1:0] SPEED_LIM_RST = REG_W'(4) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEP_DIST  = 2'd0,
    CFG_SEP_GAIN  = 2'd1,
    CFG_SPEED_LIM = 2'd2
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQ_R,
    ST_RAD_CMP,
    ST_ROOT,
    ST_GAIN,
    ST_SPAN,
    ST_FDIV,
    ST_FWAIT,
    ST_STEP_LO,
    ST_STEP_HI,
    ST_STEP_ADD,
    ST_CLOSE,
    ST_NRM_Y,
    ST_NRM_Z,
    ST_NRM_L,
    ST_NRM_CMP,
    ST_LEN,
    ST_SC_MUL,
    ST_SC_DIV,
    ST_SC_WAIT,
    ST_EMIT
  } state_t;

  // start and finish strobes of an iterative unit
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_rsp_t;

  // saturate an accumulator value to a result field
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-POS_W:0] top;
    logic signed [POS_W-1:0] res;
    top = v[ACC_W-1:POS_W-1];
    if ((top == '0) || (top == '1)) begin
      res = v[POS_W-1:0];
    end else if (v[ACC_W-1]) begin
      res = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(POS_W-1){1'b1}}};
    end
    return res;
  endfunction

  // saturate a wide sum to the accumulator width
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-ACC_W:0] top;
    logic signed [ACC_W-1:0] res;
    top = v[SUM_W-1:ACC_W-1];
    if ((top == '0) || (top == '1)) begin
      res = v[ACC_W-1:0];
    end else if (v[SUM_W-1]) begin
      res = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(ACC_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

FILE: hdl/separation_force_accumulator.sv
// separation_force_accumulator: top level, sequencer, accumulator and config registers
// depends on sfa_pkg, sfa_mul, sfa_sqrt, sfa_div
//
// Takes one neighbour beat at a time and adds its repulsion to a saturating
// three-axis accumulator; the beat flagged last closes the run, clamps the sum
// to speed_limit and emits one result beat, then clears the accumulator. All
// arithmetic goes through one registered 32x32 multiplier, a bit-serial square
// root and a bit-serial divider under one sequencer, and in_ready is high only
// while the sequencer is idle. A self entry or a neighbour outside the bounding
// cube is skipped before any multiply, one outside the exact radius once the
// squared distance is compared, and a neighbour inside the radius waits on the
// square root and the divider. A last beat within the limit is emitted unscaled;
// one beyond it is scaled with one root and three divides, and a waiting result
// is held back while out_ready is low. Configuration writes take effect at once.
module separation_force_accumulator
  import sfa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [REG_W-1:0]         cfg_wdata,
  // neighbour beats
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [POS_W-1:0]  in_self_x,
  input  logic signed [POS_W-1:0]  in_self_y,
  input  logic signed [POS_W-1:0]  in_self_z,
  input  logic signed [POS_W-1:0]  in_other_x,
  input  logic signed [POS_W-1:0]  in_other_y,
  input  logic signed [POS_W-1:0]  in_other_z,
  input  logic                     in_is_self,
  input  logic                     in_last_item,
  // result beats
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [POS_W-1:0]  out_push_x,
  output logic signed [POS_W-1:0]  out_push_y,
  output logic signed [POS_W-1:0]  out_push_z
);

  state_t                      state_r, state_nxt;
  logic [REG_W-1:0]            sep_dist_r, sep_gain_r, speed_lim_r;
  logic signed [DELTA_W-1:0]   delta_r [3];
  logic                        is_self_r, last_r;
  logic signed [ACC_W-1:0]     acc_r [3];
  logic signed [ACC_W-1:0]     acc_nxt [3];
  logic [PROD_W-1:0]           sum_r, sum_nxt;
  logic [ROOT_W-1:0]           root_r, root_nxt;
  logic [DIV_NUM_W-1:0]        fac_r, fac_nxt;
  logic [PROD_W-1:0]           plo_r, plo_nxt;
  logic [1:0]                  axis_r, axis_nxt;
  logic signed [POS_W-1:0]     res_r [3];
  logic signed [POS_W-1:0]     res_nxt [3];
  logic                        out_valid_r;
  logic signed [POS_W-1:0]     out_x_r, out_y_r, out_z_r;
  logic                        emit_go;
  logic                        in_fire;

  // shared units
  logic [MUL_W-1:0]            mul_a, mul_b;
  logic [PROD_W-1:0]           prod;
  unit_req_t                   sq_req, dv_req;
  unit_rsp_t                   sq_rsp, dv_rsp;
  logic [RAD_W-1:0]            sq_rad;
  logic [ROOT_W-1:0]           sq_root;
  logic [DIV_NUM_W-1:0]        dv_num, dv_quo;
  logic [DIV_DEN_W-1:0]        dv_den;

  // magnitudes
  logic [DELTA_W-1:0]          mag_d [3];
  logic [ACC_W-1:0]            mag_a [3];
  logic                        far;
  logic [REG_W-1:0]            a_sel;
  logic [STEP_W-1:0]           step_p;
  logic [STEP_W-1:0]           step_c;
  logic [CAP_BITS:0]           step_cap;
  logic signed [SUM_W-1:0]     step_s;
  logic signed [SUM_W-1:0]     step_sum;
  logic [DIV_NUM_W-1:0]        sc_q;

  sfa_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  sfa_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (sq_req),
    .radicand (sq_rad),
    .rsp      (sq_rsp),
    .root_r   (sq_root)
  );

  sfa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dv_req),
    .num   (dv_num),
    .den   (dv_den),
    .rsp   (dv_rsp),
    .quo_r (dv_quo)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign emit_go  = !out_valid_r || out_ready;

  // magnitudes of deltas and accumulator components
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = delta_r[i][DELTA_W-1] ? DELTA_W'(-delta_r[i]) : DELTA_W'(delta_r[i]);
      mag_a[i] = acc_r[i][ACC_W-1] ? ACC_W'(-acc_r[i]) : ACC_W'(acc_r[i]);
    end
    far = (mag_d[0] > DELTA_W'(sep_dist_r)) || (mag_d[1] > DELTA_W'(sep_dist_r)) ||
          (mag_d[2] > DELTA_W'(sep_dist_r));
  end

  // per-axis step: |delta|*f >> frac, capped, signed, saturating add
  always_comb begin
    a_sel    = mag_d[axis_r][REG_W-1:0];
    step_p   = STEP_W'(plo_r) + (STEP_W'(prod) << FAC_HALF);
    step_c   = step_p >> FRAC_BITS;
    step_cap = (step_c > STEP_W'(64'd1 << CAP_BITS)) ? (CAP_BITS+1)'(64'd1 << CAP_BITS)
                                                     : step_c[CAP_BITS:0];
    step_s   = delta_r[axis_r][DELTA_W-1] ? -SUM_W'(step_cap) : SUM_W'(step_cap);
    step_sum = SUM_W'(acc_r[axis_r]) + step_s;
    sc_q     = dv_quo;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    root_nxt  = root_r;
    fac_nxt   = fac_r;
    plo_nxt   = plo_r;
    axis_nxt  = axis_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    mul_a     = '0;
    mul_b     = '0;
    sq_req    = '0;
    dv_req    = '0;
    sq_rad    = sum_r;
    dv_num    = '0;
    dv_den    = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_CHECK;
        end
      end
      // skip self and neighbours outside the bounding cube
      ST_CHECK: begin
        if (is_self_r || far) begin
          state_nxt = ST_CLOSE;
        end else begin
          mul_a     = MUL_W'(mag_d[0][REG_W-1:0]);
          mul_b     = MUL_W'(mag_d[0][REG_W-1:0]);
          state_nxt = ST_SQ_Y;
        end
      end
      ST_SQ_Y: begin
        sum_nxt   = prod;
        mul_a     = MUL_W'(mag_d[1][REG_W-1:0]);
        mul_b     = MUL_W'(mag_d[1][REG_W-1:0]);
        state_nxt = ST_SQ_Z;
      end
      ST_SQ_Z: begin
        sum_nxt   = sum_r + prod;
        mul_a     = MUL_W'(mag_d[2][REG_W-1:0]);
        mul_b     = MUL_W'(mag_d[2][REG_W-1:0]);
        state_nxt = ST_SQ_R;
      end
      ST_SQ_R: begin
        sum_nxt   = sum_r + prod;
        mul_a     = MUL_W'(sep_dist_r);
        mul_b     = MUL_W'(sep_dist_r);
        state_nxt = ST_RAD_CMP;
      end
      // coincident or beyond the radius: skip
      ST_RAD_CMP: begin
        if ((sum_r == '0) || (sum_r > prod)) begin
          state_nxt = ST_CLOSE;
        end else begin
          sq_req.start = 1'b1;
          state_nxt    = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sq_rsp.done) begin
          root_nxt  = sq_root;
          state_nxt = ST_GAIN;
        end
      end
      ST_GAIN: begin
        mul_a     = MUL_W'(sep_gain_r);
        mul_b     = MUL_W'(sep_dist_r - root_r[REG_W-1:0]);
        state_nxt = ST_SPAN;
      end
      ST_SPAN: begin
        sum_nxt   = prod;
        mul_a     = MUL_W'(sep_dist_r);
        mul_b     = MUL_W'(root_r[REG_W-1:0]);
        state_nxt = ST_FDIV;
      end
      // factor = gain*(s-d)*2^frac / (s*d)
      ST_FDIV: begin
        dv_req.start = 1'b1;
        dv_num       = {sum_r[2*REG_W-1:0], {FRAC_BITS{1'b0}}};
        dv_den       = prod[DIV_DEN_W-1:0];
        state_nxt    = ST_FWAIT;
      end
      ST_FWAIT: begin
        if (dv_rsp.done) begin
          fac_nxt   = dv_quo;
          axis_nxt  = '0;
          state_nxt = ST_STEP_LO;
        end
      end
      ST_STEP_LO: begin
        mul_a     = MUL_W'(a_sel);
        mul_b     = MUL_W'(fac_r[FAC_HALF-1:0]);
        state_nxt = ST_STEP_HI;
      end
      ST_STEP_HI: begin
        plo_nxt   = prod;
        mul_a     = MUL_W'(a_sel);
        mul_b     = MUL_W'(fac_r[DIV_NUM_W-1:FAC_HALF]);
        state_nxt = ST_STEP_ADD;
      end
      ST_STEP_ADD: begin
        acc_nxt[axis_r] = sat_acc(step_sum);
        if (axis_r == 2'd2) begin
          state_nxt = ST_CLOSE;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = ST_STEP_LO;
        end
      end
      // end of run: squared length of the sum
      ST_CLOSE: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else begin
          mul_a     = mag_a[0];
          mul_b     = mag_a[0];
          state_nxt = ST_NRM_Y;
        end
      end
      ST_NRM_Y: begin
        sum_nxt   = prod;
        mul_a     = mag_a[1];
        mul_b     = mag_a[1];
        state_nxt = ST_NRM_Z;
      end
      ST_NRM_Z: begin
        sum_nxt   = sum_r + prod;
        mul_a     = mag_a[2];
        mul_b     = mag_a[2];
        state_nxt = ST_NRM_L;
      end
      ST_NRM_L: begin
        sum_nxt   = sum_r + prod;
        mul_a     = MUL_W'(speed_lim_r);
        mul_b     = MUL_W'(speed_lim_r);
        state_nxt = ST_NRM_CMP;
      end
      ST_NRM_CMP: begin
        if (sum_r > prod) begin
          sq_req.start = 1'b1;
          state_nxt    = ST_LEN;
        end else begin
          for (int i = 0; i < 3; i++) begin
            res_nxt[i] = sat_pos(acc_r[i]);
          end
          state_nxt = ST_EMIT;
        end
      end
      ST_LEN: begin
        if (sq_rsp.done) begin
          root_nxt  = sq_root;
          axis_nxt  = '0;
          state_nxt = ST_SC_MUL;
        end
      end
      // component * limit / length
      ST_SC_MUL: begin
        mul_a     = mag_a[axis_r];
        mul_b     = MUL_W'(speed_lim_r);
        state_nxt = ST_SC_DIV;
      end
      ST_SC_DIV: begin
        dv_req.start = 1'b1;
        dv_num       = prod[DIV_NUM_W-1:0];
        dv_den       = DIV_DEN_W'(root_r);
        state_nxt    = ST_SC_WAIT;
      end
      ST_SC_WAIT: begin
        if (dv_rsp.done) begin
          res_nxt[axis_r] = acc_r[axis_r][ACC_W-1] ? -POS_W'(sc_q) : POS_W'(sc_q);
          if (axis_r == 2'd2) begin
            state_nxt = ST_EMIT;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            state_nxt = ST_SC_MUL;
          end
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          for (int i = 0; i < 3; i++) begin
            acc_nxt[i] = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state, accumulator and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sep_dist_r  <= SEP_DIST_RST;
      sep_gain_r  <= SEP_GAIN_RST;
      speed_lim_r <= SPEED_LIM_RST;
      out_valid_r <= 1'b0;
      axis_r      <= '0;
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      acc_r   <= acc_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEP_DIST:  sep_dist_r  <= cfg_wdata;
          CFG_SEP_GAIN:  sep_gain_r  <= cfg_wdata;
          CFG_SPEED_LIM: speed_lim_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (state_r == ST_EMIT && emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    root_r <= root_nxt;
    fac_r  <= fac_nxt;
    plo_r  <= plo_nxt;
    res_r  <= res_nxt;
    if (in_fire) begin
      delta_r[0] <= {in_self_x[POS_W-1], in_self_x} - {in_other_x[POS_W-1], in_other_x};
      delta_r[1] <= {in_self_y[POS_W-1], in_self_y} - {in_other_y[POS_W-1], in_other_y};
      delta_r[2] <= {in_self_z[POS_W-1], in_self_z} - {in_other_z[POS_W-1], in_other_z};
      is_self_r  <= in_is_self;
      last_r     <= in_last_item;
    end
    if (state_r == ST_EMIT && emit_go) begin
      out_x_r <= res_r[0];
      out_y_r <= res_r[1];
      out_z_r <= res_r[2];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_push_x = out_x_r;
  assign out_push_y = out_y_r;
  assign out_push_z = out_z_r;

  // a result beat only comes out of the emit step
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result beat raised outside emit");

  // the accumulator is empty once a run is emitted
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && emit_go) |=>
      (acc_r[0] == '0 && acc_r[1] == '0 && acc_r[2] == '0))
    else $error("accumulator not cleared after emit");

  // no new beat while a neighbour is in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input taken during processing");

  // root and divider are never busy together
  a_unit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(sq_rsp.busy && dv_rsp.busy))
    else $error("square root and divider overlap");

endmodule

FILE: hdl/sfa_mul.sv
// sfa_mul: shared unsigned multiplier with registered product
// depends on sfa_pkg
module sfa_mul
  import sfa_pkg::*;
(
  input  logic              clk,
  input  logic [MUL_W-1:0]  op_a,
  input  logic [MUL_W-1:0]  op_b,
  output logic [PROD_W-1:0] prod_r
);

  // product lands in the cycle after the operands
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

FILE: hdl/sfa_sqrt.sv
// sfa_sqrt: digit-by-digit integer square root, one result bit per cycle
// depends on sfa_pkg
module sfa_sqrt
  import sfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  unit_req_t         req,
  input  logic [RAD_W-1:0]  radicand,
  output unit_rsp_t         rsp,
  output logic [ROOT_W-1:0] root_r
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]    rad_r;
  logic [ROOT_W+1:0]   rem_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [ROOT_W+3:0]   rem_sh;
  logic [ROOT_W+3:0]   trial;
  logic [ROOT_W+3:0]   diff;
  logic                ge;
  logic [ROOT_W+1:0]   rem_nxt;
  logic [ROOT_W-1:0]   root_nxt;

  // trial subtract of the next digit pair
  always_comb begin
    rem_sh   = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    ge       = (rem_sh >= trial);
    diff     = rem_sh - trial;
    rem_nxt  = ge ? diff[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
    root_nxt = {root_r[ROOT_W-2:0], ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;

endmodule

FILE: hdl/sfa_div.sv
// sfa_div: restoring unsigned divider, one quotient bit per cycle
// depends on sfa_pkg
module sfa_div
  import sfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  unit_req_t            req,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output unit_rsp_t            rsp,
  output logic [DIV_NUM_W-1:0] quo_r
);

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  // shift in the next numerator bit and trial subtract
  always_comb begin
    rem_sh = {rem_r, quo_r[DIV_NUM_W-1]};
    ge     = (rem_sh >= {1'b0, den_r});
    diff   = rem_sh - {1'b0, den_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // numerator shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (req.start) begin
      den_r <= den;
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      quo_r <= {quo_r[DIV_NUM_W-2:0], ge};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;

endmodule

FILE: sim/tb_separation_force_accumulator.sv
// tb_separation_force_accumulator: self-checking testbench for the separation force accumulator
// predicts every push beat with a scoreboard class and drives beats with plain tasks
// depends on sfa_pkg and separation_force_accumulator
`timescale 1ns / 1ps

module tb_separation_force_accumulator;
  import sfa_pkg::*;

  localparam int                   WATCHDOG_LIMIT = 6000;
  localparam int                   DRAIN_CYCLES   = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 2'd3;
  localparam longint               STEP_CAP       = 64'sd1 << CAP_BITS;
  localparam longint               ACC_HI         = 64'sd2147483647;
  localparam longint               ACC_LO         = -64'sd2147483648;

  typedef struct packed {
    logic signed [POS_W-1:0] self_x;
    logic signed [POS_W-1:0] self_y;
    logic signed [POS_W-1:0] self_z;
    logic signed [POS_W-1:0] other_x;
    logic signed [POS_W-1:0] other_y;
    logic signed [POS_W-1:0] other_z;
    logic                    is_self;
    logic                    last_item;
  } neighbour_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } push_t;

  // predicts the repulsion of each run and checks the push beats in order
  class repulsion_scoreboard;
    longint unsigned sep_dist, sep_gain, speed_lim;
    longint          acc_x, acc_y, acc_z;
    push_t           expected_push[$];
    int              errors;

    function new();
      sep_dist  = 8192;
      sep_gain  = 4096;
      speed_lim = 16384;
      acc_x = 0; acc_y = 0; acc_z = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      if (idx == CFG_SEP_DIST) sep_dist = val;
      else if (idx == CFG_SEP_GAIN) sep_gain = val;
      else if (idx == CFG_SPEED_LIM) speed_lim = val;
    endfunction

    function longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function longint unsigned int_root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint add_sat(longint acc, longint d, longint unsigned f);
      longint unsigned a, c;
      longint s;
      a = magnitude(d);
      if (f != 0 && a > 64'hFFFF_FFFF_FFFF_FFFF / f) c = STEP_CAP;
      else c = (a * f) >> FRAC_BITS;
      if (c > STEP_CAP) c = STEP_CAP;
      s = (d < 0) ? -longint'(c) : longint'(c);
      acc = acc + s;
      if (acc > ACC_HI) acc = ACC_HI;
      if (acc < ACC_LO) acc = ACC_LO;
      return acc;
    endfunction

    function logic signed [POS_W-1:0] clip_pos(longint v);
      if (v > 64'sd8388607) v = 64'sd8388607;
      if (v < -64'sd8388608) v = -64'sd8388608;
      return v[POS_W-1:0];
    endfunction

    function longint scaled(longint a, longint unsigned lim, longint unsigned len);
      longint unsigned q;
      q = magnitude(a) * lim / len;
      return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    // accepted neighbour beat: fold it into the running sum
    function void note_neighbour(neighbour_t nb);
      longint dx, dy, dz, px, py, pz;
      longint unsigned s, d2, dlen, t, m, q, r, n2, len;
      bit use_it;
      push_t p;
      dx = longint'(nb.self_x) - longint'(nb.other_x);
      dy = longint'(nb.self_y) - longint'(nb.other_y);
      dz = longint'(nb.self_z) - longint'(nb.other_z);
      s = sep_dist;
      use_it = !nb.is_self;
      if (magnitude(dx) > s || magnitude(dy) > s || magnitude(dz) > s) use_it = 0;
      if (use_it) begin
        d2 = magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy)
           + magnitude(dz) * magnitude(dz);
        dlen = int_root(d2);
        if (dlen != 0 && d2 <= s * s) begin
          t = sep_gain * (s - dlen);
          m = s * dlen;
          q = t / m;
          r = t % m;
          for (int i = 0; i < FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= m) begin
              r = r - m;
              q = q | 64'd1;
            end
          end
          acc_x = add_sat(acc_x, dx, q);
          acc_y = add_sat(acc_y, dy, q);
          acc_z = add_sat(acc_z, dz, q);
        end
      end
      if (!nb.last_item) return;
      // close the run: clamp to the speed limit, emit, clear
      px = acc_x; py = acc_y; pz = acc_z;
      n2 = magnitude(px) * magnitude(px) + magnitude(py) * magnitude(py)
         + magnitude(pz) * magnitude(pz);
      if (n2 > speed_lim * speed_lim) begin
        len = int_root(n2);
        px = scaled(px, speed_lim, len);
        py = scaled(py, speed_lim, len);
        pz = scaled(pz, speed_lim, len);
      end
      p.x = clip_pos(px);
      p.y = clip_pos(py);
      p.z = clip_pos(pz);
      expected_push = {expected_push, p};
      acc_x = 0; acc_y = 0; acc_z = 0;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    // accepted push beat: compare with the oldest prediction
    task check_push(push_t got);
      push_t want;
      if (expected_push.size() == 0) begin
        report($sformatf("unexpected push %0d %0d %0d", got.x, got.y, got.z));
        return;
      end
      want = expected_push.pop_front();
      if (got.x !== want.x) report($sformatf("push_x got %0d want %0d", got.x, want.x));
      if (got.y !== want.y) report($sformatf("push_y got %0d want %0d", got.y, want.y));
      if (got.z !== want.z) report($sformatf("push_z got %0d want %0d", got.z, want.z));
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_SEP_DIST;
  logic [REG_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [POS_W-1:0] in_self_x = '0, in_self_y = '0, in_self_z = '0;
  logic signed [POS_W-1:0] in_other_x = '0, in_other_y = '0, in_other_z = '0;
  logic                    in_is_self = 1'b0, in_last_item = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [POS_W-1:0] out_push_x, out_push_y, out_push_z;

  repulsion_scoreboard sb = new();
  int  quiet_cycles = 0;
  int  stall_left = 0;
  bit  no_idle = 0;

  always #4 clk = ~clk;

  separation_force_accumulator u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_self_x(in_self_x), .in_self_y(in_self_y), .in_self_z(in_self_z),
    .in_other_x(in_other_x), .in_other_y(in_other_y), .in_other_z(in_other_z),
    .in_is_self(in_is_self), .in_last_item(in_last_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_push_x(out_push_x), .out_push_y(out_push_y), .out_push_z(out_push_z)
  );

  // result side: check each push; random stalls, a few long ones, except in no_idle phases
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_push('{x: out_push_x, y: out_push_y, z: out_push_z});
    end
    if (no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [POS_W-1:0] sat24(longint v);
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[POS_W-1:0];
  endfunction

  function automatic neighbour_t mk(longint sx, longint sy, longint sz,
                                    longint ox, longint oy, longint oz, bit me, bit last);
    neighbour_t nb;
    nb.self_x = sat24(sx); nb.self_y = sat24(sy); nb.self_z = sat24(sz);
    nb.other_x = sat24(ox); nb.other_y = sat24(oy); nb.other_z = sat24(oz);
    nb.is_self = me;
    nb.last_item = last;
    return nb;
  endfunction

  // neighbour placed around the subject, mostly near the radius
  function automatic neighbour_t near_neighbour(longint unsigned s, bit last);
    neighbour_t nb;
    longint span, off[3], pos[3];
    span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : longint'(s + s / 8 + 1);
    if (span > 64'sd8388608) span = 64'sd8388608;
    for (int i = 0; i < 3; i++) begin
      pos[i] = longint'($signed(24'($urandom())));
      off[i] = longint'($urandom_range(0, 2 * span)) - span;
    end
    nb = mk(pos[0], pos[1], pos[2], pos[0] + off[0], pos[1] + off[1], pos[2] + off[2],
            ($urandom_range(0, 15) == 0), last);
    return nb;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // one neighbour beat; valid stays up into the next beat when there is no gap
  task automatic send_neighbour(neighbour_t nb);
    int gap;
    in_self_x  <= nb.self_x;  in_self_y  <= nb.self_y;  in_self_z  <= nb.self_z;
    in_other_x <= nb.other_x; in_other_y <= nb.other_y; in_other_z <= nb.other_z;
    in_is_self <= nb.is_self;
    in_last_item <= nb.last_item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_neighbour(nb);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for every push, then let the block settle before a register write
  task automatic drain();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (sb.expected_push.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    int sent;
    neighbour_t nb;
    sent = 0;
    while (sent < count) begin
      int run;
      run = $urandom_range(1, 8);
      for (int k = 0; k < run; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: anywhere in the field, random flags
          nb = mk($signed(24'($urandom())), $signed(24'($urandom())),
                  $signed(24'($urandom())), $signed(24'($urandom())),
                  $signed(24'($urandom())), $signed(24'($urandom())),
                  $urandom_range(0, 1), $urandom_range(0, 5) == 0);
        end else begin
          nb = near_neighbour(sb.sep_dist, k == run - 1);
        end
        send_neighbour(nb);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats at reset settings
    send_neighbour(mk(100, 200, 300, 100, 200, 300, 1, 1));   // self entry as last
    send_neighbour(mk(5, 5, 5, 5, 5, 5, 0, 1));               // closer than one lsb
    send_neighbour(mk(0, 0, 0, 1, 0, 0, 0, 0));               // one lsb away
    send_neighbour(mk(0, 0, 0, 0, -1, 0, 0, 1));
    send_neighbour(mk(0, 0, 0, 8192, 0, 0, 0, 1));            // right at the radius
    send_neighbour(mk(0, 0, 0, 0, 0, -8193, 0, 1));           // just beyond
    send_neighbour(mk(0, 0, 0, 5000, 5000, 5000, 0, 1));      // axes inside, radius out
    send_neighbour(mk(8388607, 8388607, 8388607, -8388608, -8388608, -8388608, 0, 1));
    send_neighbour(mk(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 1, 0));
    send_neighbour(mk(8388607, -8388608, 0, 8388600, -8388600, 3, 0, 1));
    for (int i = 0; i < 6; i++) begin
      send_neighbour(mk(0, 0, 0, i + 1, -i - 2, 2 * i + 1, 0, i == 5));  // pile up, clamp
    end
    drain();
    write_reg(CFG_SEP_DIST, 23'd1);
    write_reg(CFG_SEP_GAIN, 23'h7FFFFF);
    write_reg(CFG_SPEED_LIM, 23'd0);                          // zero limit
    send_neighbour(mk(0, 0, 0, 1, 0, 0, 0, 1));
    send_neighbour(mk(0, 0, 0, 1, 1, 0, 0, 1));
    drain();
    write_reg(CFG_SEP_DIST, 23'h7FFFFF);
    write_reg(CFG_SPEED_LIM, 23'h7FFFFF);
    write_reg(CFG_UNUSED, 23'h123456);
    // huge steps drive the sum into saturation
    send_neighbour(mk(0, 0, 0, 1, 0, 0, 0, 0));
    send_neighbour(mk(0, 0, 0, -3000000, 2000000, 1, 0, 0));
    send_neighbour(mk(0, 0, 0, -3000000, 2000000, 1, 0, 1));
    drain();
    write_reg(CFG_SEP_DIST, 23'd0);                           // zero radius
    send_neighbour(mk(0, 0, 0, 1, 0, 0, 0, 1));
    send_neighbour(mk(0, 0, 0, 0, 0, 0, 0, 1));
    drain();

    // random phases over a spread of settings, fixed ones (reset values and extremes) first
    for (int ph = 0; ph < 12; ph++) begin
      logic [REG_W-1:0] d, g, l;
      case (ph)
        0: begin d = 23'd8192; g = 23'd4096; l = 23'd16384; end
        1: begin d = 23'h7FFFFF; g = 23'h7FFFFF; l = 23'h7FFFFF; end
        2: begin d = 23'd1; g = 23'h7FFFFF; l = 23'd0; end
        3: begin d = 23'd4096; g = 23'd0; l = 23'd100; end
        4: begin d = 23'd3; g = 23'd1 << 20; l = 23'd1; end
        5: begin d = 23'h7FFFFF; g = 23'd1; l = 23'd0; end
        default: begin
          d = REG_W'($urandom_range(1, 8388607) >> $urandom_range(0, 20));
          g = 23'($urandom()) >> $urandom_range(0, 22);
          l = 23'($urandom()) >> $urandom_range(0, 22);
        end
      endcase
      no_idle = (ph % 4 == 3);
      write_reg(CFG_SEP_DIST, d);
      write_reg(CFG_SEP_GAIN, g);
      write_reg(CFG_SPEED_LIM, l);
      random_phase(150);
      drain();
    end

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: separation_force_accumulator.f
hdl/sfa_pkg.sv
hdl/sfa_mul.sv
hdl/sfa_sqrt.sv
hdl/sfa_div.sv
hdl/separation_force_accumulator.sv
sim/tb_separation_force_accumulator.sv
